[hdl/deq_pkg.sv]
// Shared constants, codes, states and command type for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

  // Storage geometry
  localparam int DEPTH      = 16;
  localparam int ENTRY_BITS = 8;
  localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS   = $clog2(DEPTH + 1);

  // Fixed port widths
  localparam int FUNC_BITS   = 3;
  localparam int ITEM_BITS   = 8;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 5;

  // Operation codes
  typedef enum logic [FUNC_BITS-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5
  } op_e;

  // Result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;  // capture the incoming word
    logic exec;  // carry out the captured operation
  } deq_cmd_t;

endpackage

[hdl/deq_ctrl.sv]
// Controller state machine: sequences capture, execute and response of each word.
`timescale 1ns / 1ps

module deq_ctrl import deq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_ready_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  output deq_cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/deq_datapath.sv]
// Datapath: ring storage, front/rear indices, entry count and result registers.
`timescale 1ns / 1ps

module deq_datapath import deq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  deq_cmd_t               cmd_i,
  input  logic [FUNC_BITS-1:0]   func_i,
  input  logic [ITEM_BITS-1:0]   item_in_i,
  output logic [ITEM_BITS-1:0]   item_out_o,
  output logic [STATUS_BITS-1:0] status_o,
  output logic [COUNT_BITS-1:0]  entry_count_o
);

  localparam logic [IDX_BITS-1:0] LastIdx = IDX_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FullCnt = CNT_BITS'(DEPTH);

  logic [ENTRY_BITS-1:0] mem [DEPTH];

  logic [FUNC_BITS-1:0]  func_q;
  logic [ENTRY_BITS-1:0] item_q;
  logic [IDX_BITS-1:0]   front_q, front_d;
  logic [IDX_BITS-1:0]   rear_q, rear_d;
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic [ENTRY_BITS-1:0] rd_q;
  logic                  rd_ok_q, rd_ok_d;
  status_e               status_q, status_d;

  logic [IDX_BITS-1:0] front_prev, front_next, rear_prev, rear_next;
  logic [IDX_BITS-1:0] addr;
  logic                wr_en;
  logic                full, empty;

  // Capture the incoming word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      item_q <= item_in_i[ENTRY_BITS-1:0];
    end
  end

  // Index wrap in both directions
  assign front_prev = (front_q == '0) ? LastIdx : front_q - 1'b1;
  assign front_next = (front_q == LastIdx) ? '0 : front_q + 1'b1;
  assign rear_prev  = (rear_q == '0) ? LastIdx : rear_q - 1'b1;
  assign rear_next  = (rear_q == LastIdx) ? '0 : rear_q + 1'b1;
  assign full       = (count_q == FullCnt);
  assign empty      = (count_q == '0);

  // Operation decode
  always_comb begin
    front_d  = front_q;
    rear_d   = rear_q;
    count_d  = count_q;
    addr     = front_q;
    wr_en    = 1'b0;
    rd_ok_d  = 1'b0;
    status_d = ST_OK;
    case (op_e'(func_q))
      OP_PUSH_FRONT: begin
        addr = front_prev;
        if (full) begin
          status_d = ST_OVER;
        end else begin
          wr_en   = 1'b1;
          front_d = front_prev;
          count_d = count_q + 1'b1;
        end
      end
      OP_PUSH_REAR: begin
        addr = rear_q;
        if (full) begin
          status_d = ST_OVER;
        end else begin
          wr_en   = 1'b1;
          rear_d  = rear_next;
          count_d = count_q + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        addr = front_q;
        if (empty) begin
          status_d = ST_UNDER;
        end else begin
          rd_ok_d = 1'b1;
          front_d = front_next;
          count_d = count_q - 1'b1;
        end
      end
      OP_POP_REAR: begin
        addr = rear_prev;
        if (empty) begin
          status_d = ST_UNDER;
        end else begin
          rd_ok_d = 1'b1;
          rear_d  = rear_prev;
          count_d = count_q - 1'b1;
        end
      end
      OP_PEEK_FRONT: begin
        addr = front_q;
        if (empty) begin
          status_d = ST_UNDER;
        end else begin
          rd_ok_d = 1'b1;
        end
      end
      OP_PEEK_REAR: begin
        addr = rear_prev;
        if (empty) begin
          status_d = ST_UNDER;
        end else begin
          rd_ok_d = 1'b1;
        end
      end
      default: begin
        // unused codes leave everything as it is
      end
    endcase
  end

  // Ring storage, one port, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (wr_en) begin
        mem[addr] <= item_q;
      end
      rd_q <= mem[addr];
    end
  end

  // Indices and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
      count_q <= '0;
      rd_ok_q <= 1'b0;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      rear_q  <= rear_d;
      count_q <= count_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  // Result status
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
    end
  end

  assign item_out_o    = rd_ok_q ? ITEM_BITS'(rd_q) : '0;
  assign status_o      = status_q;
  assign entry_count_o = COUNT_BITS'(count_q);

endmodule

[hdl/double_ended_queue.sv]
// Top level of the double-ended queue: controller and datapath.
`timescale 1ns / 1ps

// Bounded double-ended queue of DEPTH byte entries held in a ring buffer.
// Each input word carries one operation (push/pop/peek at front or rear) and
// yields exactly one result word with the entry read, a status and the count
// held afterwards. A push into a full queue is dropped with overflow status;
// a pop or peek on an empty queue reports underflow with zero data. The block
// handles one word at a time: it takes a word in the idle state, executes it
// in the next cycle through the single storage port with registered read
// data, and presents the result in the response state until out_ready_i
// takes it. No clearing pass is needed after reset.
module double_ended_queue import deq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [FUNC_BITS-1:0]   func_i,
  input  logic [ITEM_BITS-1:0]   item_in_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ITEM_BITS-1:0]   item_out_o,
  output logic [STATUS_BITS-1:0] status_o,
  output logic [COUNT_BITS-1:0]  entry_count_o
);

  deq_cmd_t cmd;

  // Sequencing
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // Storage and indices
  deq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (func_i),
    .item_in_i     (item_in_i),
    .item_out_o    (item_out_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

endmodule

[hdl/deq_checker.sv]
// Port-level checks for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps

module deq_checker import deq_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [ITEM_BITS-1:0]   item_out_o,
  input logic [STATUS_BITS-1:0] status_o,
  input logic [COUNT_BITS-1:0]  entry_count_o
);

  // One word in flight: never ready for input while a result waits
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  // Overflow carries zero data and a full count
  a_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OVER) |->
      (item_out_o == '0 && entry_count_o == COUNT_BITS'(DEPTH)))
    else $error("overflow result with bad data or count");

  // Underflow only on an empty queue, with zero data
  a_under_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_UNDER) |->
      (item_out_o == '0 && entry_count_o == '0))
    else $error("underflow result with bad data or count");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(item_out_o) && $stable(status_o) &&
       $stable(entry_count_o)))
    else $error("stalled result changed");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

[verif/tb_double_ended_queue.sv]
// Self-checking testbench for the double-ended queue: random bursts, stalls and a ring predictor.
`timescale 1ns / 1ps

module tb_double_ended_queue;
  import deq_pkg::*;

  // Codes the block must ignore
  localparam logic [FUNC_BITS-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [FUNC_BITS-1:0] OP_UNUSED_HI = 3'd7;

  localparam int RANDOM_WORDS = 1340;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no word moving on either side
  localparam int HOLD_AFTER   = 300;   // results taken before the long receiver hold-off
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic [FUNC_BITS-1:0] func;
    logic [ITEM_BITS-1:0] item;
  } deq_word_t;

  typedef struct {
    logic [ITEM_BITS-1:0]  item_out;
    status_e               status;
    logic [COUNT_BITS-1:0] entry_count;
  } deq_result_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [FUNC_BITS-1:0]   func_i;
  logic [ITEM_BITS-1:0]   item_in_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [ITEM_BITS-1:0]   item_out_o;
  logic [STATUS_BITS-1:0] status_o;
  logic [COUNT_BITS-1:0]  entry_count_o;

  double_ended_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .item_in_i     (item_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .item_out_o    (item_out_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  deq_word_t   pending_words[$];
  deq_result_t expected_results[$];
  int          fail_count = 0;

  // Shadow ring buffer
  logic [ENTRY_BITS-1:0] ring_shadow [DEPTH];
  int                    front_slot = 0;
  int                    rear_slot  = 0;
  int                    held_n     = 0;

  function automatic int slot_fwd(input int s);
    return (s + 1 >= DEPTH) ? 0 : s + 1;
  endfunction

  function automatic int slot_back(input int s);
    return (s == 0) ? DEPTH - 1 : s - 1;
  endfunction

  // Apply one word to the shadow ring and return the result it should give
  function automatic deq_result_t apply_word(input deq_word_t w);
    deq_result_t r;
    r.item_out = '0;
    r.status   = ST_OK;
    case (w.func)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (held_n >= DEPTH) begin
          r.status = ST_OVER;
        end else if (w.func == OP_PUSH_FRONT) begin
          front_slot = slot_back(front_slot);
          ring_shadow[front_slot] = w.item[ENTRY_BITS-1:0];
          held_n++;
        end else begin
          ring_shadow[rear_slot] = w.item[ENTRY_BITS-1:0];
          rear_slot = slot_fwd(rear_slot);
          held_n++;
        end
      end
      OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
        if (held_n == 0) begin
          r.status = ST_UNDER;
        end else begin
          case (w.func)
            OP_POP_FRONT: begin
              r.item_out = ITEM_BITS'(ring_shadow[front_slot]);
              front_slot = slot_fwd(front_slot);
              held_n--;
            end
            OP_POP_REAR: begin
              rear_slot  = slot_back(rear_slot);
              r.item_out = ITEM_BITS'(ring_shadow[rear_slot]);
              held_n--;
            end
            OP_PEEK_FRONT: r.item_out = ITEM_BITS'(ring_shadow[front_slot]);
            default:       r.item_out = ITEM_BITS'(ring_shadow[slot_back(rear_slot)]);
          endcase
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_BITS'(held_n);
    return r;
  endfunction

  function automatic void add_word(input logic [FUNC_BITS-1:0] f, input logic [ITEM_BITS-1:0] v);
    deq_word_t w;
    w.func = f;
    w.item = v;
    pending_words.push_back(w);
  endfunction

  // Stimulus: directed corner words, then random runs biased to fill or drain
  initial begin
    mix_e                 mix;
    int                   mix_left;
    int                   push_pct;
    int                   pick;
    logic [FUNC_BITS-1:0] f;

    for (int i = 0; i < DEPTH; i++) ring_shadow[i] = '0;

    // empty queue: every read underflows
    add_word(OP_POP_FRONT, 8'h00);
    add_word(OP_POP_REAR, 8'hFF);
    add_word(OP_PEEK_FRONT, 8'h00);
    add_word(OP_PEEK_REAR, 8'hFF);
    // codes that change nothing
    add_word(OP_UNUSED_LO, 8'hFF);
    add_word(OP_UNUSED_HI, 8'h00);
    // push front on empty wraps the front index backwards; peek rear wraps too
    add_word(OP_PUSH_FRONT, 8'h00);
    add_word(OP_PEEK_REAR, 8'h3C);
    add_word(OP_PUSH_REAR, 8'hFF);
    add_word(OP_PUSH_FRONT, 8'hA5);
    add_word(OP_PUSH_REAR, 8'h5A);
    add_word(OP_PEEK_FRONT, 8'h00);
    add_word(OP_PEEK_REAR, 8'h00);
    add_word(OP_POP_REAR, 8'h00);
    add_word(OP_POP_FRONT, 8'h00);
    add_word(OP_POP_FRONT, 8'h00);
    add_word(OP_POP_REAR, 8'h00);
    add_word(OP_POP_REAR, 8'h00);

    mix_left = 0;
    mix      = MIX_EVEN;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (mix_left == 0) begin
        mix_left = $urandom_range(20, 60);
        mix      = mix_e'($urandom_range(0, 2));
      end
      mix_left--;
      push_pct = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 25 : 45;
      pick     = $urandom_range(0, 99);
      if (pick >= 97) begin
        f = $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;
      end else if (pick < push_pct) begin
        f = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
      end else begin
        f = FUNC_BITS'($urandom_range(int'(OP_POP_FRONT), int'(OP_PEEK_REAR)));
      end
      add_word(f, ITEM_BITS'($urandom_range(0, 255)));
    end
  end

  // Reset, once
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Sender: bursts of random length with random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    deq_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      func_i     <= '0;
      item_in_i  <= '0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        in_valid_i <= 1'b1;
        func_i     <= w.func;
        item_in_i  <= w.item;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall rate changes per segment, plus one long hold-off
  int rx_taken;
  int seg_left;
  int stall_pct;
  int hold_left;
  bit hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_taken  = 0;
      seg_left  = 0;
      stall_pct = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) rx_taken++;
      if (!hold_done && rx_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(16, 80);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Monitor: check each result word, then predict from each accepted input word
  deq_result_t exp_r;
  deq_word_t   taken_w;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: item_out %0d status %0d entry_count %0d",
                 item_out_o, status_o, entry_count_o);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (item_out_o !== exp_r.item_out) begin
            $error("item_out: expected %0d, got %0d", exp_r.item_out, item_out_o);
            fail_count++;
          end
          if (status_o !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status_o);
            fail_count++;
          end
          if (entry_count_o !== exp_r.entry_count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.entry_count, entry_count_o);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        taken_w.func = func_i;
        taken_w.item = item_in_i;
        expected_results.push_back(apply_word(taken_w));
      end
    end
  end

  // Watchdog: too long with no word moving
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("double_ended_queue verification failed");
        $finish;
      end
    end
  end

  // End of run
  initial begin
    @(posedge rst_ni);
    @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i) @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d result words never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("double_ended_queue verification clean");
    end else begin
      $display("double_ended_queue verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/deq_pkg.sv
hdl/deq_ctrl.sv
hdl/deq_datapath.sv
hdl/double_ended_queue.sv
hdl/deq_checker.sv
verif/tb_double_ended_queue.sv
